### design/rbm_la_pkg.sv
`default_nettype none
package rbm_la_pkg;

  localparam int MAX_VISIBLE     = 32;
  localparam int MAX_HIDDEN      = 64;
  localparam int CORR_TABLE_SIZE = 256;

  localparam int VIS_W      = $clog2(MAX_VISIBLE);
  localparam int HID_W      = $clog2(MAX_HIDDEN);
  localparam int VCNT_W     = 6;
  localparam int HCNT_W     = 7;
  localparam int CNT_W      = 7;
  localparam int VAL_W      = 16;
  localparam int LANE_W     = 22;
  localparam int THETA_W    = 23;
  localparam int TOT_W      = 34;
  localparam int OUT_W      = 32;
  localparam int CORR_W     = 12;
  localparam int CORR_IDX_W = $clog2(CORR_TABLE_SIZE);
  // |theta| below 2^MAG_LIM_W (8.0 in Q12) gets a table correction
  localparam int MAG_LIM_W  = 15;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_W  = 2'd0,
    OP_LOAD_VB = 2'd1,
    OP_LOAD_HB = 2'd2,
    OP_EVAL    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [VIS_W-1:0]        row;
    logic [HID_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic [MAX_VISIBLE-1:0]  spins;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_ACC_END,
    ST_TAIL,
    ST_TAIL_END1,
    ST_TAIL_END2,
    ST_FIN
  } back_state_e;

  typedef logic [CORR_W-1:0] corr_tab_t [CORR_TABLE_SIZE];

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned LN2_Q30 = 64'd744261118;

  // shift-subtract quotient, used only while building the constant table
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q, rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      q   = q << 1;
      if (rem >= b) begin
        rem  = rem - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + exp(-2u)) in Q12 at bucket midpoints, exact Q30 integer evaluation
  function automatic corr_tab_t build_corr_table();
    corr_tab_t       t;
    longint unsigned two_u, kk, r, term, e, z, z2, p, acc, c, n;
    longint          sum;
    for (int k = 0; k < CORR_TABLE_SIZE; k++) begin
      two_u = (longint'(2 * k + 1) << 33) >> CORR_IDX_W;
      kk    = udiv64(two_u, LN2_Q30);
      r     = two_u - kk * LN2_Q30;
      sum   = longint'(Q30_ONE);
      term  = Q30_ONE;
      for (n = 1; n <= 14; n++) begin
        term = (term * r) >> 30;
        term = udiv64(term, n);
        if (n[0]) sum = sum - $signed(term);
        else      sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      if (kk >= 31) e = 0;
      else          e = longint'(unsigned'(sum)) >> kk;
      z   = udiv64(e << 30, 2 * Q30_ONE + e);
      z2  = (z * z) >> 30;
      p   = z;
      acc = 0;
      for (n = 1; n <= 25; n += 2) begin
        acc = acc + udiv64(p, n);
        p   = (p * z2) >> 30;
      end
      c    = 2 * acc;
      t[k] = CORR_W'((c + (64'd1 << 17)) >> 18);
    end
    return t;
  endfunction

  localparam corr_tab_t CORR_TABLE = build_corr_table();

endpackage
`default_nettype wire

### design/rbm_la_front.sv
`default_nettype none
module rbm_la_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [1:0]                   op_i,
  input  wire  [rbm_la_pkg::VIS_W-1:0] row_i,
  input  wire  [rbm_la_pkg::HID_W-1:0] col_i,
  input  wire  signed [15:0]           value_i,
  input  wire  [31:0]                  spins_i,
  output logic                         cmd_valid_o,
  input  wire                          cmd_pop_i,
  output rbm_la_pkg::cmd_t             cmd_o
);
  import rbm_la_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op    = op_e'(op_i);
    cmd_in.row   = row_i;
    cmd_in.col   = col_i;
    cmd_in.value = value_i;
    cmd_in.spins = spins_i;
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

### design/rbm_la_back.sv
`default_nettype none
module rbm_la_back (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [rbm_la_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [rbm_la_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                               cmd_valid_i,
  output logic                              cmd_pop_o,
  input  rbm_la_pkg::cmd_t                  cmd_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [31:0]                log_amp_o,
  output logic                              saturated_o
);
  import rbm_la_pkg::*;

  logic signed [VAL_W-1:0] weight_mem [MAX_VISIBLE][MAX_HIDDEN];
  logic signed [VAL_W-1:0] vbias_mem  [MAX_VISIBLE];
  logic signed [VAL_W-1:0] hbias_mem  [MAX_HIDDEN];

  back_state_e state_q, state_d;
  logic [VCNT_W-1:0] vcfg_q, nv_q, nv_d;
  logic [HCNT_W-1:0] hcfg_q, nh_q, nh_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MAX_VISIBLE-1:0] spins_q;
  logic rd_vld_q, rd_sign_q, hb_vld_q, th_vld_q, out_valid_q;
  logic signed [VAL_W-1:0]   weight_rd_q [MAX_HIDDEN];
  logic signed [VAL_W-1:0]   vb_rd_q, hb_rd_q;
  logic signed [LANE_W-1:0]  lanes_q [MAX_HIDDEN];
  logic signed [LANE_W-1:0]  lanes_d [MAX_HIDDEN];
  logic signed [THETA_W-1:0] theta_q, theta_d;
  logic signed [TOT_W-1:0]   total_q, total_d;
  logic [THETA_W-1:0] mag;
  logic [CORR_W-1:0]  corr;
  logic signed [OUT_W-1:0] log_amp_q;
  logic sat_q, sat_hi, sat_lo;

  // control outputs of the sequencer
  logic start, issue_acc, issue_tail, out_load, acc_last, tail_last;
  logic we_w, we_vb, we_hb;

  assign acc_last  = (cnt_q == CNT_W'(nv_q) - CNT_W'(1));
  assign tail_last = (cnt_q == CNT_W'(nh_q) - CNT_W'(1));

  always_comb begin
    nv_d = vcfg_q;
    if (vcfg_q == '0) nv_d = VCNT_W'(1);
    else if (vcfg_q > VCNT_W'(MAX_VISIBLE)) nv_d = VCNT_W'(MAX_VISIBLE);
    nh_d = hcfg_q;
    if (hcfg_q == '0) nh_d = HCNT_W'(1);
    else if (hcfg_q > HCNT_W'(MAX_HIDDEN)) nh_d = HCNT_W'(MAX_HIDDEN);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.op == OP_EVAL) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (acc_last) state_d = ST_ACC_END;
      end
      ST_ACC_END:   state_d = ST_TAIL;
      ST_TAIL: begin
        if (tail_last) state_d = ST_TAIL_END1;
      end
      ST_TAIL_END1: state_d = ST_TAIL_END2;
      ST_TAIL_END2: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    start      = 1'b0;
    issue_acc  = 1'b0;
    issue_tail = 1'b0;
    out_load   = 1'b0;
    we_w       = 1'b0;
    we_vb      = 1'b0;
    we_hb      = 1'b0;
    cnt_d      = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_LOAD_W:  we_w  = 1'b1;
            OP_LOAD_VB: we_vb = 1'b1;
            OP_LOAD_HB: we_hb = 1'b1;
            default:    start = 1'b1;
          endcase
          cnt_d = '0;
        end
      end
      ST_ACC: begin
        issue_acc = 1'b1;
        cnt_d     = cnt_q + CNT_W'(1);
      end
      ST_ACC_END: cnt_d = '0;
      ST_TAIL: begin
        issue_tail = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
      end
      ST_FIN: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // memories: one write port, registered reads
  always_ff @(posedge clk_i) begin
    if (we_w)  weight_mem[cmd_i.row][cmd_i.col] <= cmd_i.value;
    if (we_vb) vbias_mem[cmd_i.row] <= cmd_i.value;
    if (we_hb) hbias_mem[cmd_i.col] <= cmd_i.value;
    weight_rd_q <= weight_mem[cnt_q[VIS_W-1:0]];
    vb_rd_q     <= vbias_mem[cnt_q[VIS_W-1:0]];
    hb_rd_q     <= hbias_mem[cnt_q[HID_W-1:0]];
  end

  // lane update: clear on start, accumulate rows, then shift lanes out one per cycle
  always_comb begin
    lanes_d = lanes_q;
    if (start) begin
      for (int k = 0; k < MAX_HIDDEN; k++) lanes_d[k] = '0;
    end else if (rd_vld_q) begin
      for (int k = 0; k < MAX_HIDDEN; k++) begin
        if (rd_sign_q) lanes_d[k] = lanes_q[k] + LANE_W'(weight_rd_q[k]);
        else           lanes_d[k] = lanes_q[k] - LANE_W'(weight_rd_q[k]);
      end
    end else if (hb_vld_q) begin
      for (int k = 0; k < MAX_HIDDEN - 1; k++) lanes_d[k] = lanes_q[k+1];
      lanes_d[MAX_HIDDEN-1] = '0;
    end
  end

  assign theta_d = THETA_W'(lanes_q[0]) + THETA_W'(hb_rd_q);
  assign mag     = theta_q[THETA_W-1] ? THETA_W'(-theta_q) : THETA_W'(theta_q);
  assign corr    = (mag[THETA_W-1:MAG_LIM_W] == '0)
                   ? CORR_TABLE[mag[MAG_LIM_W-1 -: CORR_IDX_W]] : '0;

  always_comb begin
    total_d = total_q;
    if (start) total_d = '0;
    else if (rd_vld_q) begin
      if (rd_sign_q) total_d = total_q + TOT_W'(vb_rd_q);
      else           total_d = total_q - TOT_W'(vb_rd_q);
    end else if (th_vld_q) begin
      total_d = total_q + $signed(TOT_W'(mag)) + $signed(TOT_W'(corr));
    end
  end

  assign sat_hi = !total_q[TOT_W-1] && (total_q[TOT_W-2:OUT_W-1] != '0);
  assign sat_lo = total_q[TOT_W-1] && (total_q[TOT_W-2:OUT_W-1] != '1);

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    total_q <= total_d;
    theta_q <= theta_d;
    if (start) spins_q <= cmd_i.spins;
    if (out_load) begin
      sat_q <= sat_hi || sat_lo;
      if (sat_hi)      log_amp_q <= {1'b0, {(OUT_W-1){1'b1}}};
      else if (sat_lo) log_amp_q <= {1'b1, {(OUT_W-1){1'b0}}};
      else             log_amp_q <= total_q[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcfg_q      <= VCNT_W'(MAX_VISIBLE);
      hcfg_q      <= HCNT_W'(MAX_HIDDEN);
      nv_q        <= VCNT_W'(MAX_VISIBLE);
      nh_q        <= HCNT_W'(MAX_HIDDEN);
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_sign_q   <= 1'b0;
      hb_vld_q    <= 1'b0;
      th_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= issue_acc;
      rd_sign_q <= spins_q[cnt_q[VIS_W-1:0]];
      hb_vld_q  <= issue_tail;
      th_vld_q  <= hb_vld_q;
      if (start) begin
        nv_q <= nv_d;
        nh_q <= nh_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VISIBLE_COUNT: vcfg_q <= cfg_wdata_i[VCNT_W-1:0];
          CFG_HIDDEN_COUNT:  hcfg_q <= cfg_wdata_i[HCNT_W-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign log_amp_o   = log_amp_q;
  assign saturated_o = sat_q;

endmodule
`default_nettype wire

### design/rbm_log_amplitude.sv
`default_nettype none
// RBM log-amplitude evaluator (Q3.12 parameters, result Q.12 in 32 bits).
// Items with op 0/1/2 load one weight, visible bias or hidden bias and give
// no result; op 3 evaluates the spin vector and gives one result. Items pass
// a two-entry queue to an execution engine, so the input keeps accepting
// while the engine works, until the queue is full. An evaluation reads
// visible_count weight-memory rows, one per cycle, into 64 hidden lanes,
// then hidden_count lanes, one per cycle, go through the log(2cosh)
// correction table into the total. A result waits in the output register;
// the next evaluation finishes only once it has been taken. Weight and bias
// stores are undefined until written.
module rbm_log_amplitude (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire  [rbm_la_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [rbm_la_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [1:0]                        op_i,
  input  wire  [4:0]                        row_i,
  input  wire  [5:0]                        col_i,
  input  wire  signed [15:0]                value_i,
  input  wire  [31:0]                       spins_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [31:0]                log_amp_o,
  output logic                              saturated_o
);
  import rbm_la_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  rbm_la_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .spins_i     (spins_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  rbm_la_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .log_amp_o   (log_amp_o),
    .saturated_o (saturated_o)
  );

endmodule
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rbm_la_pkg::*;

  typedef struct {
    logic signed [31:0] amp;
    logic               sat;
  } amp_t;

  class log_amp_tracker;
    logic signed [15:0] wt [32][64];
    logic signed [15:0] vbias [32];
    logic signed [15:0] hbias [64];
    logic [11:0]        corr [256];
    logic [5:0]         vis_cnt;
    logic [6:0]         hid_cnt;
    amp_t               pending_amps [$];
    int                 errors;

    function new();
      vis_cnt = 6'd32;
      hid_cnt = 7'd64;
      errors  = 0;
      make_corr();
    endfunction

    // ln(1 + exp(-2u)) at bucket midpoints, Q30 integer math rounded to Q12
    function void make_corr();
      longint unsigned x, k2, r, term, e, z, z2, p, acc;
      longint          s;
      for (int k = 0; k < 256; k++) begin
        x = ((64'd2 * k + 1) << 33) / 256;
        k2 = x / 64'd744261118;
        r = x - k2 * 64'd744261118;
        s = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int n = 1; n <= 14; n++) begin
          term = ((term * r) >> 30) / n;
          if (n % 2) s = s - longint'(term);
          else s = s + longint'(term);
        end
        if (s < 0) s = 0;
        e = (k2 >= 31) ? 64'd0 : (unsigned'(s) >> k2);
        z = (e << 30) / ((64'd2 << 30) + e);
        z2 = (z * z) >> 30;
        p = z;
        acc = 0;
        for (int n = 1; n <= 25; n += 2) begin
          acc = acc + p / n;
          p = (p * z2) >> 30;
        end
        corr[k] = 12'(((2 * acc) + (64'd1 << 17)) >> 18);
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
      if (idx == CFG_VISIBLE_COUNT) vis_cnt = data[5:0];
      else hid_cnt = data;
    endfunction

    function void note_item(op_e op, logic [4:0] row, logic [5:0] col,
                            logic signed [15:0] value, logic [31:0] spins);
      int     nv, nh;
      longint total, theta, mag;
      amp_t   res;
      case (op)
        OP_LOAD_W:  wt[row][col] = value;
        OP_LOAD_VB: vbias[row] = value;
        OP_LOAD_HB: hbias[col] = value;
        default: begin
          nv = (vis_cnt == 0) ? 1 : (vis_cnt > 32 ? 32 : vis_cnt);
          nh = (hid_cnt == 0) ? 1 : (hid_cnt > 64 ? 64 : hid_cnt);
          total = 0;
          for (int i = 0; i < nv; i++)
            total += spins[i] ? longint'(vbias[i]) : -longint'(vbias[i]);
          for (int j = 0; j < nh; j++) begin
            theta = hbias[j];
            for (int i = 0; i < nv; i++)
              theta += spins[i] ? longint'(wt[i][j]) : -longint'(wt[i][j]);
            mag = (theta < 0) ? -theta : theta;
            total += mag;
            if (mag < 32768) total += corr[mag >> 7];
          end
          res.sat = 1'b0;
          if (total > 64'sd2147483647) begin
            total = 64'sd2147483647;
            res.sat = 1'b1;
          end else if (total < -64'sd2147483648) begin
            total = -64'sd2147483648;
            res.sat = 1'b1;
          end
          res.amp = total[31:0];
          pending_amps = {pending_amps, res};
        end
      endcase
    endfunction

    function void check_result(logic signed [31:0] amp, logic sat);
      amp_t want;
      if (pending_amps.size() == 0) begin
        $display("%0t: unexpected result log_amp=%0d saturated=%0b", $time, amp, sat);
        errors++;
        return;
      end
      want = pending_amps.pop_front();
      if (amp !== want.amp) begin
        $display("%0t: log_amp expected %0d actual %0d", $time, want.amp, amp);
        errors++;
      end
      if (sat !== want.sat) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.sat, sat);
        errors++;
      end
    endfunction
  endclass

  // hidden columns that get filled; evaluations never reach past them
  localparam int FILL_COLS = 16;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i = '0;
  logic [4:0]         row_i = '0;
  logic [5:0]         col_i = '0;
  logic signed [15:0] value_i = '0;
  logic [31:0]        spins_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] log_amp_o;
  logic               saturated_o;

  log_amp_tracker tracker = new();
  bit fast_mode;
  bit hold_req;
  bit small_vals;

  rbm_log_amplitude uut (.*);

  always #4 clk_i = ~clk_i;

  initial begin
    #8ms;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_item(op_e op, logic [4:0] row, logic [5:0] col,
                           logic signed [15:0] value, logic [31:0] spins);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    row_i <= row;
    col_i <= col;
    value_i <= value;
    spins_i <= spins;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_item(op, row, col, value, spins);
  endtask

  function automatic logic signed [15:0] rand_value();
    if (small_vals) return 16'($signed($urandom_range(0, 400)) - 200);
    return 16'($urandom);
  endfunction

  task automatic send_random();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) send_item(OP_EVAL, 5'($urandom), 6'($urandom), 16'($urandom), $urandom);
    else if (sel < 8) send_item(OP_LOAD_W, 5'($urandom), 6'($urandom), rand_value(), $urandom);
    else if (sel == 8) send_item(OP_LOAD_VB, 5'($urandom), 6'($urandom), rand_value(), $urandom);
    else send_item(OP_LOAD_HB, 5'($urandom), 6'($urandom), rand_value(), $urandom);
  endtask

  // block is idle: no result pending, queued loads drained
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending_amps.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [6:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, data);
  endtask

  // receiver
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        stall = 3000;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_result(log_amp_o, saturated_o);
    end
  end

  initial begin
    int vc [8] = '{32, 0, 1, 63, 5, 17, 32, 9};
    int hc [8] = '{16, 0, 1, 16, 3, 11, 16, 7};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // evaluations stay within the filled hidden columns
    write_reg(CFG_HIDDEN_COUNT, 7'(FILL_COLS));

    // fill every entry an evaluation can read
    fast_mode = 1;
    for (int i = 0; i < 32; i++)
      for (int j = 0; j < FILL_COLS; j++)
        send_item(OP_LOAD_W, 5'(i), 6'(j), 16'($urandom), $urandom);
    for (int i = 0; i < 32; i++) send_item(OP_LOAD_VB, 5'(i), '0, 16'($urandom), '0);
    for (int j = 0; j < FILL_COLS; j++) send_item(OP_LOAD_HB, '0, 6'(j), 16'($urandom), '0);
    fast_mode = 0;

    // directed: field extremes, every op
    send_item(OP_LOAD_W, 5'd0, 6'd0, 16'sh7fff, 32'hffff_ffff);
    send_item(OP_LOAD_W, 5'd31, 6'd63, 16'sh8000, 32'h0);
    send_item(OP_LOAD_VB, 5'd31, 6'd63, 16'sh8000, 32'h0);
    send_item(OP_LOAD_VB, 5'd0, 6'd0, 16'sh7fff, 32'h0);
    send_item(OP_LOAD_HB, 5'd31, 6'd63, 16'sh7fff, 32'h0);
    send_item(OP_LOAD_HB, 5'd0, 6'd0, 16'sh0000, 32'h0);
    send_item(OP_EVAL, 5'd0, 6'd0, 16'sh0, 32'h0000_0000);
    send_item(OP_EVAL, 5'd31, 6'd63, 16'shffff, 32'hffff_ffff);
    send_item(OP_EVAL, 5'd0, 6'd0, 16'sh0, 32'haaaa_aaaa);
    send_item(OP_EVAL, 5'd0, 6'd0, 16'sh0, 32'h5555_5555);
    // set hidden unit 0 weights to one LSB so its pre-activation lands near zero
    for (int i = 0; i < 32; i++) send_item(OP_LOAD_W, 5'(i), 6'd0, 16'sh0001, '0);
    send_item(OP_EVAL, 5'd0, 6'd0, 16'sh0, 32'h0000_ffff);
    send_item(OP_EVAL, 5'd0, 6'd0, 16'sh0, 32'h8000_0001);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_reg(CFG_VISIBLE_COUNT, 7'(vc[ph]));
      write_reg(CFG_HIDDEN_COUNT, 7'(hc[ph]));
      small_vals = ph[0];
      if (ph == 2) fast_mode = 1;
      if (ph == 5) hold_req = 1;
      for (int n = 0; n < 56; n++) begin
        if (ph == 5 && n < 40) fast_mode = 1;
        else if (ph != 2) fast_mode = 0;
        send_random();
      end
      fast_mode = 0;
    end

    in_valid_i <= 1'b0;
    while (tracker.pending_amps.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (tracker.errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
